// File: sv/lsdi_pkg.sv
`timescale 1ns / 1ps

package lsdi_pkg;

  // Table geometry: key is {label, sdi}
  localparam int KEY_ENTRIES = 1024;
  localparam int KEY_W       = $clog2(KEY_ENTRIES);
  localparam int WORD_W      = 32;
  localparam int LABEL_W     = 8;
  localparam int SDI_W       = 2;
  localparam int DATA_W      = 19;
  localparam int SSM_W       = 2;
  localparam int VALUE_W     = SSM_W + DATA_W;

  // Word bit positions
  localparam int LABEL_LSB = 24;
  localparam int SDI_LSB   = 22;
  localparam int DATA_LSB  = 3;
  localparam int SSM_LSB   = 1;

  // One table entry: valid mark plus last {ssm, data}
  typedef struct packed {
    logic               vld;
    logic [VALUE_W-1:0] value;
  } lsdi_entry_t;

  // Write request from the filter stage into the table
  typedef struct packed {
    logic             we;
    logic [KEY_W-1:0] addr;
    lsdi_entry_t      data;
  } lsdi_wr_t;

  // Table sequencer: clearing sweep after reset, then normal operation
  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } lsdi_state_t;

  function automatic logic [KEY_W-1:0] word_key(input logic [WORD_W-1:0] word);
    return word[WORD_W-1:SDI_LSB];
  endfunction

  function automatic logic [VALUE_W-1:0] word_value(input logic [WORD_W-1:0] word);
    return {word[SSM_LSB +: SSM_W], word[DATA_LSB +: DATA_W]};
  endfunction

endpackage

// File: sv/label_sdi_change_filter_unit.sv
`timescale 1ns / 1ps

// ARINC 429 label/SDI change filter. Each received word is looked up in a
// 1024-entry table keyed by {label, SDI}; it is passed on with its decoded
// fields only when its entry was never seen or its {SSM, data} changed, and
// the entry is then updated. Parity takes no part in the decision. After
// reset the table is swept clear entry by entry while in_stall is high.
// After that one word is taken every cycle: a two-stage pipeline reads the
// table at accept and compares in the next cycle, a changed word is written
// back as it is loaded into the output register, and a write from the
// previous cycle is forwarded to the compare. The table has one read and
// one write port, which sets the one-word-per-cycle rate. A changed word
// that finds the output register full and out_stall high waits in the
// compare stage, and in_stall stays high for as long as it waits; dropped
// words never wait.
module label_sdi_change_filter_unit import lsdi_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // input requests
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [WORD_W-1:0]   in_rx_word,
  // result requests
  output logic                out_valid,
  input  logic                out_stall,
  output logic [LABEL_W-1:0]  out_label,
  output logic [SDI_W-1:0]    out_sdi,
  output logic [DATA_W-1:0]   out_data,
  output logic [SSM_W-1:0]    out_ssm,
  output logic [WORD_W-1:0]   out_word
);

  logic             tbl_busy;
  logic [KEY_W-1:0] rd_addr;
  lsdi_entry_t      rd_data;
  lsdi_wr_t         wr;

  logic              s1_valid_r;
  logic [WORD_W-1:0] s1_word_r;
  logic [KEY_W-1:0]  s1_key;
  logic [VALUE_W-1:0] s1_value;
  lsdi_entry_t       s1_entry;
  logic              s1_hit;
  logic              s1_go;

  logic               fwd_en_r;
  logic [KEY_W-1:0]   fwd_key_r;
  logic [VALUE_W-1:0] fwd_val_r;

  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  logic              out_free;
  logic              out_load;
  logic              in_acc;

  lsdi_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr),
    .busy    (tbl_busy)
  );

  // Compare stage: entry is the table read or the write from last cycle
  assign s1_key   = word_key(s1_word_r);
  assign s1_value = word_value(s1_word_r);

  always_comb begin
    s1_entry = rd_data;
    if (fwd_en_r && fwd_key_r == s1_key) begin
      s1_entry.vld   = 1'b1;
      s1_entry.value = fwd_val_r;
    end
  end

  assign s1_hit   = s1_entry.vld && (s1_entry.value == s1_value);
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (s1_hit || out_free);
  assign out_load = s1_go && !s1_hit;

  // Handshake on the input side
  assign in_stall = tbl_busy || (s1_valid_r && !s1_go);
  assign in_acc   = in_valid && !in_stall;

  // Read the new word's entry, or re-read the held one while stalled
  assign rd_addr = in_acc ? word_key(in_rx_word) : s1_key;

  // Write back a changed or new entry
  always_comb begin
    wr.we         = out_load;
    wr.addr       = s1_key;
    wr.data.vld   = 1'b1;
    wr.data.value = s1_value;
  end

  // Stage and forwarding registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_en_r   <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      fwd_en_r <= wr.we && !tbl_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_word_r <= in_rx_word;
    end
    fwd_key_r <= wr.addr;
    fwd_val_r <= wr.data.value;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r <= s1_word_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_label = out_word_r[LABEL_LSB +: LABEL_W];
  assign out_sdi   = out_word_r[SDI_LSB +: SDI_W];
  assign out_data  = out_word_r[DATA_LSB +: DATA_W];
  assign out_ssm   = out_word_r[SSM_LSB +: SSM_W];

  // No word enters while the table is being cleared
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_busy |-> !in_acc)
    else $error("word accepted during table clear");

  // A result is only pushed where the output register has room
  a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || !out_stall))
    else $error("result overwrote a pending result");

  // An entry written last cycle is seen as valid with its new value
  a_forward: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(wr.we && !tbl_busy) && s1_valid_r && $past(wr.addr) == s1_key)
      |-> (s1_entry.vld && s1_entry.value == $past(wr.data.value)))
    else $error("write of previous cycle not forwarded");

  // A word equal to the one just forwarded under the same key is dropped
  a_repeat_drop: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(out_load) && s1_valid_r && $past(s1_valid_r) &&
     s1_key == $past(s1_key) && s1_value == $past(s1_value)) |-> !out_load)
    else $error("repeated value forwarded twice");

endmodule

// File: sv/lsdi_table.sv
`timescale 1ns / 1ps

module lsdi_table import lsdi_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [KEY_W-1:0] rd_addr,
  output lsdi_entry_t      rd_data,
  input  lsdi_wr_t         wr,
  output logic             busy
);

  lsdi_entry_t mem [KEY_ENTRIES];

  lsdi_state_t      state_r, state_nxt;
  logic [KEY_W-1:0] clr_idx_r, clr_idx_nxt;

  logic             mem_we;
  logic [KEY_W-1:0] mem_waddr;
  lsdi_entry_t      mem_wdata;

  // Sweep state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  // Next state and write port selection
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    busy        = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = wr.addr;
    mem_wdata   = wr.data;
    unique case (state_r)
      ST_CLEAR: begin
        busy        = 1'b1;
        mem_we      = 1'b1;
        mem_waddr   = clr_idx_r;
        mem_wdata   = '0;
        clr_idx_nxt = clr_idx_r + KEY_W'(1);
        if (&clr_idx_r) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        mem_we = wr.we;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Memory: one write port, one registered read port (read-first)
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  // Sweep visits every entry and then stops
  a_sweep_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && &clr_idx_r) |=> (state_r == ST_RUN && clr_idx_r == '0))
    else $error("clearing sweep did not finish cleanly");

  a_no_user_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !(mem_we && mem_waddr != clr_idx_r))
    else $error("table written outside sweep while clearing");

  a_run_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |=> (state_r == ST_RUN))
    else $error("table left run state without reset");

endmodule

// File: tb/sv/tb_label_sdi_change_filter_unit.sv
`timescale 1ns / 1ps

module tb_label_sdi_change_filter_unit;
  import lsdi_pkg::*;

  localparam int WATCHDOG_CYCLES = 5000;
  localparam int DRAIN_CYCLES    = 10;
  localparam int HOT_KEYS        = 16;

  // One forwarded word with its decoded fields
  typedef struct {
    logic [LABEL_W-1:0] label;
    logic [SDI_W-1:0]   sdi;
    logic [DATA_W-1:0]  data;
    logic [SSM_W-1:0]   ssm;
    logic [WORD_W-1:0]  word;
  } filtered_word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [WORD_W-1:0]  in_rx_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [LABEL_W-1:0] out_label;
  logic [SDI_W-1:0]   out_sdi;
  logic [DATA_W-1:0]  out_data;
  logic [SSM_W-1:0]   out_ssm;
  logic [WORD_W-1:0]  out_word;

  // Local copy of the label/SDI table
  bit                 seen_valid [KEY_ENTRIES];
  logic [VALUE_W-1:0] seen_value [KEY_ENTRIES];
  filtered_word_t     changed_words [$];
  filtered_word_t     head_word;
  logic [KEY_W-1:0]   hot_keys [HOT_KEYS];

  bit                 idle_on = 1'b1;
  int unsigned        stall_left = 0;
  int unsigned        quiet_cycles = 0;
  int unsigned        fail_count = 0;

  label_sdi_change_filter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_word (in_rx_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_label  (out_label),
    .out_sdi    (out_sdi),
    .out_data   (out_data),
    .out_ssm    (out_ssm),
    .out_word   (out_word)
  );

  always #5 clk = ~clk;

  // Table update for one accepted word; queues the result if it changed
  function automatic void track_word(input logic [WORD_W-1:0] w);
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    filtered_word_t     fw;
    key   = w[WORD_W-1:SDI_LSB];
    value = {w[SSM_LSB +: SSM_W], w[DATA_LSB +: DATA_W]};
    if (seen_valid[key] && seen_value[key] == value) return;
    seen_valid[key] = 1'b1;
    seen_value[key] = value;
    fw.label = w[LABEL_LSB +: LABEL_W];
    fw.sdi   = w[SDI_LSB +: SDI_W];
    fw.data  = w[DATA_LSB +: DATA_W];
    fw.ssm   = w[SSM_LSB +: SSM_W];
    fw.word  = w;
    changed_words.push_back(fw);
  endfunction

  // {key, data, ssm, parity}; value holds {ssm, data}
  function automatic logic [WORD_W-1:0] pack_word(input logic [KEY_W-1:0] key,
                                                  input logic [VALUE_W-1:0] value,
                                                  input logic parity);
    return {key, value[DATA_W-1:0], value[VALUE_W-1:DATA_W], parity};
  endfunction

  // Send one request; valid stays high afterward so back-to-back words go out
  task automatic send_word(input logic [WORD_W-1:0] w);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_word(w);
  endtask

  task automatic test_field_extremes();
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF);  // repeat of top key, dropped
    send_word(32'h8000_0000);
    send_word(32'h0040_0000);
    send_word(32'h0080_0000);
    send_word(32'h003F_FFF8);  // key 0, data all ones
    send_word(32'h0000_0006);  // key 0, ssm all ones
    send_word(32'h0000_0004);
  endtask

  // Parity alone never counts as a change
  task automatic test_parity_only();
    send_word(32'h1234_5678);
    send_word(32'h1234_5679);
    send_word(32'h1234_5678);
  endtask

  task automatic test_single_field_change();
    send_word(32'h5A00_0008);
    send_word(32'h5A00_000A);  // ssm lsb flips
    send_word(32'h5A20_000A);  // data msb flips
  endtask

  // Same label, each SDI is an entry of its own
  task automatic test_sdi_entries();
    for (int s = 0; s < 4; s++) send_word({8'h31, s[1:0], 19'h2_5A5A, 2'b01, 1'b0});
  endtask

  // Back-to-back hits on one key exercise the write-to-compare bypass
  task automatic test_back_to_back();
    idle_on = 1'b0;
    send_word(32'hC3C0_1110);
    send_word(32'hC3C0_1110);
    send_word(32'hC3C0_1111);
    send_word(32'hC3C0_2220);
    send_word(32'hC3C0_1110);
    send_word(32'hC3C0_1110);
    idle_on = 1'b1;
  endtask

  // Mostly a few busy keys with repeats and small changes, some wide spread
  task automatic random_words(input int count);
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    int unsigned        pick;
    for (int n = 0; n < count; n++) begin
      key  = ($urandom_range(0, 99) < 75) ? hot_keys[$urandom_range(0, HOT_KEYS - 1)]
                                          : KEY_W'($urandom_range(0, KEY_ENTRIES - 1));
      pick = $urandom_range(0, 99);
      if (seen_valid[key] && pick < 45) value = seen_value[key];
      else if (seen_valid[key] && pick < 65)
        value = seen_value[key] ^ (VALUE_W'(1) << $urandom_range(0, VALUE_W - 1));
      else value = VALUE_W'($urandom);
      send_word(pack_word(key, value, 1'($urandom)));
    end
  endtask

  task automatic test_random_traffic();
    hot_keys[0] = '0;
    hot_keys[1] = '1;
    for (int k = 2; k < HOT_KEYS; k++) hot_keys[k] = KEY_W'($urandom);
    random_words(800);
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    random_words(200);
  endtask

  // Result side back-pressure in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result check against the oldest pending change
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (changed_words.size() == 0) begin
        $error("unexpected result: out_word %h", out_word);
        fail_count++;
      end else begin
        head_word = changed_words.pop_front();
        if (out_label !== head_word.label) begin
          $error("out_label: expected %h, got %h", head_word.label, out_label);
          fail_count++;
        end
        if (out_sdi !== head_word.sdi) begin
          $error("out_sdi: expected %h, got %h", head_word.sdi, out_sdi);
          fail_count++;
        end
        if (out_data !== head_word.data) begin
          $error("out_data: expected %h, got %h", head_word.data, out_data);
          fail_count++;
        end
        if (out_ssm !== head_word.ssm) begin
          $error("out_ssm: expected %h, got %h", head_word.ssm, out_ssm);
          fail_count++;
        end
        if (out_word !== head_word.word) begin
          $error("out_word: expected %h, got %h", head_word.word, out_word);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: cycles without any request moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_field_extremes();
    test_parity_only();
    test_single_field_change();
    test_sdi_entries();
    test_back_to_back();
    test_random_traffic();
    test_full_rate();
    in_valid <= 1'b0;
    while (changed_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
